@@ rtl/core/rrp_pkg.sv @@
// ----------------------------------------------------------------------------
// rrp_pkg
// Shared types and constants of the reply parser: character codes, event and
// reply kind codes, byte classes and the item structs on both queues.
// ----------------------------------------------------------------------------
package rrp_pkg;

  // Characters of the reply syntax
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Event codes of a result item
  localparam logic [2:0] EV_CONSUMED = 3'd0;
  localparam logic [2:0] EV_PAYLOAD  = 3'd1;
  localparam logic [2:0] EV_ELEMENT  = 3'd2;
  localparam logic [2:0] EV_REPLY    = 3'd3;
  localparam logic [2:0] EV_SYNTAX   = 3'd4;
  localparam logic [2:0] EV_IGNORED  = 3'd5;

  // Reply kinds
  localparam logic [2:0] KIND_NIL     = 3'd0;
  localparam logic [2:0] KIND_STATUS  = 3'd1;
  localparam logic [2:0] KIND_ERROR   = 3'd2;
  localparam logic [2:0] KIND_INTEGER = 3'd3;
  localparam logic [2:0] KIND_BULK    = 3'd4;
  localparam logic [2:0] KIND_ARRAY   = 3'd5;

  // Depth of the classified-byte queue and of the result queue
  localparam int unsigned QUEUE_DEPTH = 2;

  // Byte classes found by the front end
  typedef enum logic [3:0] {
    CLS_DIGIT,
    CLS_CR,
    CLS_LF,
    CLS_PLUS,
    CLS_MINUS,
    CLS_COLON,
    CLS_DOLLAR,
    CLS_STAR,
    CLS_OTHER
  } byte_cls_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       new_reply;
  } rrp_in_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic [7:0]         payload;
    logic [2:0]         reply_type;
    logic signed [63:0] value;
  } rrp_out_t;

  typedef struct packed {
    logic       new_reply;
    byte_cls_e  cls;
    logic [7:0] rx_byte;
  } rrp_cls_t;

endpackage

@@ rtl/core/resp_reply_parser.sv @@
// An accepted byte is held in the byte queue; its result is held in the result queue.
// Throughput: one byte per cycle, set by the back-end parse step, while results have room.
// Two-entry queues sit before and after the parse step, so either side may stall alone.
// Reset: asynchronous, active low; queues empty, parser at message begin, nothing pending.
// ----------------------------------------------------------------------------
// resp_reply_parser
// Byte-serial parser for key-value store replies: status, error, integer,
// bulk string and array replies, one event per byte.
// ----------------------------------------------------------------------------
module resp_reply_parser #(
  parameter int unsigned LENGTH_BITS = 32,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  rrp_pkg::rrp_in_t  item_i,
  output logic              empty,
  input  logic              pop,
  output rrp_pkg::rrp_out_t result_o
);

  rrp_pkg::rrp_cls_t cls_in, cls_out;
  rrp_pkg::rrp_out_t res;
  logic              cls_empty, cls_pop;
  logic              res_push, res_full;

  // Classify incoming bytes
  rrp_front u_front (
    .item_i (item_i),
    .cls_o  (cls_in)
  );

  // Hold classified bytes between front and back
  rrp_fifo #(
    .DEPTH (rrp_pkg::QUEUE_DEPTH),
    .T     (rrp_pkg::rrp_cls_t)
  ) u_cls_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls_in),
    .full_o  (full),
    .pop_i   (cls_pop),
    .data_o  (cls_out),
    .empty_o (cls_empty)
  );

  // Parse one byte per cycle while the result queue has room
  rrp_back #(
    .LENGTH_BITS (LENGTH_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_i       (cls_out),
    .cls_valid_i (!cls_empty),
    .cls_pop_o   (cls_pop),
    .res_o       (res),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // Hold results until taken
  rrp_fifo #(
    .DEPTH (rrp_pkg::QUEUE_DEPTH),
    .T     (rrp_pkg::rrp_out_t)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

endmodule

@@ rtl/core/rrp_fifo.sv @@
// ----------------------------------------------------------------------------
// rrp_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module rrp_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter type         T     = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers with explicit wrap
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/core/rrp_front.sv @@
// ----------------------------------------------------------------------------
// rrp_front
// Front end: sorts each incoming reply byte into its syntax class.
// ----------------------------------------------------------------------------
module rrp_front (
  input  rrp_pkg::rrp_in_t  item_i,
  output rrp_pkg::rrp_cls_t cls_o
);

  rrp_pkg::byte_cls_e cls;

  // Classify the byte
  always_comb begin
    priority if (item_i.rx_byte >= rrp_pkg::CH_ZERO && item_i.rx_byte <= rrp_pkg::CH_NINE) begin
      cls = rrp_pkg::CLS_DIGIT;
    end else if (item_i.rx_byte == rrp_pkg::CH_CR) begin
      cls = rrp_pkg::CLS_CR;
    end else if (item_i.rx_byte == rrp_pkg::CH_LF) begin
      cls = rrp_pkg::CLS_LF;
    end else if (item_i.rx_byte == rrp_pkg::CH_PLUS) begin
      cls = rrp_pkg::CLS_PLUS;
    end else if (item_i.rx_byte == rrp_pkg::CH_MINUS) begin
      cls = rrp_pkg::CLS_MINUS;
    end else if (item_i.rx_byte == rrp_pkg::CH_COLON) begin
      cls = rrp_pkg::CLS_COLON;
    end else if (item_i.rx_byte == rrp_pkg::CH_DOLLAR) begin
      cls = rrp_pkg::CLS_DOLLAR;
    end else if (item_i.rx_byte == rrp_pkg::CH_STAR) begin
      cls = rrp_pkg::CLS_STAR;
    end else begin
      cls = rrp_pkg::CLS_OTHER;
    end
  end

  assign cls_o.new_reply = item_i.new_reply;
  assign cls_o.cls       = cls;
  assign cls_o.rx_byte   = item_i.rx_byte;

endmodule

@@ rtl/core/rrp_back.sv @@
// ----------------------------------------------------------------------------
// rrp_back
// Back end: per-byte parse state machine with the decimal accumulator,
// producing one result item for each classified byte.
// ----------------------------------------------------------------------------
module rrp_back #(
  parameter int unsigned LENGTH_BITS = 32,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rrp_pkg::rrp_cls_t cls_i,
  input  logic              cls_valid_i,
  output logic              cls_pop_o,
  output rrp_pkg::rrp_out_t res_o,
  output logic              res_push_o,
  input  logic              res_full_i
);

  localparam logic [3:0] PH_BEGIN      = 4'd0;
  localparam logic [3:0] PH_LINE_FIRST = 4'd1;
  localparam logic [3:0] PH_LINE_INT   = 4'd2;
  localparam logic [3:0] PH_LINE_TEXT  = 4'd3;
  localparam logic [3:0] PH_LINE_LF    = 4'd4;
  localparam logic [3:0] PH_CNT_FIRST  = 4'd5;
  localparam logic [3:0] PH_CNT_MORE   = 4'd6;
  localparam logic [3:0] PH_CNT_LF     = 4'd7;
  localparam logic [3:0] PH_ELEM_BEGIN = 4'd8;
  localparam logic [3:0] PH_LEN_FIRST  = 4'd9;
  localparam logic [3:0] PH_LEN_MORE   = 4'd10;
  localparam logic [3:0] PH_LEN_LF     = 4'd11;
  localparam logic [3:0] PH_BODY       = 4'd12;
  localparam logic [3:0] PH_BODY_LF    = 4'd13;
  localparam logic [3:0] PH_DONE       = 4'd14;
  localparam logic [3:0] PH_ERROR      = 4'd15;

  localparam logic [67:0] LEN_LIMIT = (68'd1 << LENGTH_BITS) - 68'd1;
  localparam logic [67:0] CNT_LIMIT = (68'd1 << COUNT_BITS) - 68'd1;
  localparam logic [67:0] SAT_LIMIT = 68'd1 << 63;
  localparam logic [63:0] SAT_MAG   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] INT_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;

  logic [3:0]             phase_q, phase_d, phase_e;
  logic [2:0]             kind_q, kind_d, kind_e;
  logic [63:0]            acc_q, acc_d, acc_e;
  logic                   minus_q, minus_d, minus_e;
  logic [LENGTH_BITS-1:0] body_q, body_d, body_e;
  logic [COUNT_BITS-1:0]  elems_q, elems_d, elems_e;
  logic                   inarr_q, inarr_d, inarr_e;

  logic        step;
  logic        is_len;
  logic [63:0] mac_src;
  logic [67:0] mac;
  logic [63:0] int_val;
  logic [2:0]  ev;
  logic [7:0]  pay;
  logic [63:0] val;
  logic        err;
  logic        is_digit, is_cr, is_lf;

  assign step       = cls_valid_i && !res_full_i;
  assign cls_pop_o  = step;
  assign res_push_o = step;

  // Restart at message begin when the item asks for it
  assign phase_e = cls_i.new_reply ? PH_BEGIN : phase_q;
  assign kind_e  = cls_i.new_reply ? rrp_pkg::KIND_NIL : kind_q;
  assign acc_e   = cls_i.new_reply ? '0 : acc_q;
  assign minus_e = cls_i.new_reply ? 1'b0 : minus_q;
  assign body_e  = cls_i.new_reply ? '0 : body_q;
  assign elems_e = cls_i.new_reply ? '0 : elems_q;
  assign inarr_e = cls_i.new_reply ? 1'b0 : inarr_q;

  assign is_digit = (cls_i.cls == rrp_pkg::CLS_DIGIT);
  assign is_cr    = (cls_i.cls == rrp_pkg::CLS_CR);
  assign is_lf    = (cls_i.cls == rrp_pkg::CLS_LF);

  // Shared decimal step: source times ten plus the digit
  assign is_len  = (phase_e == PH_LEN_FIRST) || (phase_e == PH_LEN_MORE);
  assign mac_src = is_len ? 64'(body_e) : acc_e;
  assign mac     = (68'(mac_src) << 3) + (68'(mac_src) << 1) + 68'(cls_i.rx_byte[3:0]);

  // Signed integer reply value, saturated to the positive or the negative limit
  assign int_val = minus_e ? (~acc_e + 64'd1) : (acc_e[63] ? INT_MAX : acc_e);

  // Parse one byte
  always_comb begin
    phase_d = phase_e;
    kind_d  = kind_e;
    acc_d   = acc_e;
    minus_d = minus_e;
    body_d  = body_e;
    elems_d = elems_e;
    inarr_d = inarr_e;
    ev      = rrp_pkg::EV_CONSUMED;
    pay     = '0;
    val     = '0;
    err     = 1'b0;

    unique case (phase_e)
      PH_BEGIN: begin
        unique case (cls_i.cls)
          rrp_pkg::CLS_PLUS: begin
            kind_d  = rrp_pkg::KIND_STATUS;
            phase_d = PH_LINE_FIRST;
          end
          rrp_pkg::CLS_MINUS: begin
            kind_d  = rrp_pkg::KIND_ERROR;
            phase_d = PH_LINE_FIRST;
          end
          rrp_pkg::CLS_COLON: begin
            kind_d  = rrp_pkg::KIND_INTEGER;
            phase_d = PH_LINE_FIRST;
          end
          rrp_pkg::CLS_DOLLAR: begin
            kind_d  = rrp_pkg::KIND_BULK;
            phase_d = PH_LEN_FIRST;
          end
          rrp_pkg::CLS_STAR: begin
            kind_d  = rrp_pkg::KIND_ARRAY;
            phase_d = PH_CNT_FIRST;
          end
          default: begin
            err = 1'b1;
          end
        endcase
      end
      PH_LINE_FIRST, PH_LINE_INT, PH_LINE_TEXT: begin
        if (is_lf || (is_cr && phase_e == PH_LINE_FIRST)) begin
          err = 1'b1;
        end else if (is_cr) begin
          phase_d = PH_LINE_LF;
        end else begin
          ev      = rrp_pkg::EV_PAYLOAD;
          pay     = cls_i.rx_byte;
          phase_d = PH_LINE_TEXT;
          if (kind_e == rrp_pkg::KIND_INTEGER && phase_e != PH_LINE_TEXT) begin
            if (is_digit) begin
              acc_d   = (mac > SAT_LIMIT) ? SAT_MAG : mac[63:0];
              phase_d = PH_LINE_INT;
            end else if (cls_i.cls == rrp_pkg::CLS_MINUS && phase_e == PH_LINE_FIRST) begin
              minus_d = 1'b1;
              phase_d = PH_LINE_INT;
            end
          end
        end
      end
      PH_LINE_LF: begin
        if (!is_lf) begin
          err = 1'b1;
        end else begin
          ev      = rrp_pkg::EV_REPLY;
          phase_d = PH_DONE;
          if (kind_e == rrp_pkg::KIND_INTEGER) begin
            val = int_val;
          end
        end
      end
      PH_CNT_FIRST, PH_CNT_MORE: begin
        if (is_digit) begin
          if (mac > CNT_LIMIT) begin
            err = 1'b1;
          end else begin
            acc_d   = mac[63:0];
            phase_d = PH_CNT_MORE;
          end
        end else if (is_cr && phase_e == PH_CNT_MORE) begin
          phase_d = PH_CNT_LF;
        end else begin
          err = 1'b1;
        end
      end
      PH_CNT_LF: begin
        if (!is_lf) begin
          err = 1'b1;
        end else if (acc_e == '0) begin
          ev      = rrp_pkg::EV_REPLY;
          phase_d = PH_DONE;
        end else begin
          inarr_d = 1'b1;
          elems_d = COUNT_BITS'(acc_e);
          phase_d = PH_ELEM_BEGIN;
        end
      end
      PH_ELEM_BEGIN: begin
        if (cls_i.cls == rrp_pkg::CLS_DOLLAR) begin
          phase_d = PH_LEN_FIRST;
        end else begin
          err = 1'b1;
        end
      end
      PH_LEN_FIRST, PH_LEN_MORE: begin
        if (is_digit) begin
          if (mac > LEN_LIMIT) begin
            err = 1'b1;
          end else begin
            body_d  = mac[LENGTH_BITS-1:0];
            phase_d = PH_LEN_MORE;
          end
        end else if (is_cr && phase_e == PH_LEN_MORE) begin
          phase_d = PH_LEN_LF;
        end else begin
          err = 1'b1;
        end
      end
      PH_LEN_LF: begin
        if (!is_lf) begin
          err = 1'b1;
        end else begin
          phase_d = PH_BODY;
        end
      end
      PH_BODY: begin
        if (body_e != '0) begin
          body_d = body_e - LENGTH_BITS'(1);
          ev     = rrp_pkg::EV_PAYLOAD;
          pay    = cls_i.rx_byte;
        end else if (is_cr) begin
          phase_d = PH_BODY_LF;
        end else begin
          err = 1'b1;
        end
      end
      PH_BODY_LF: begin
        if (!is_lf) begin
          err = 1'b1;
        end else if (inarr_e) begin
          elems_d = elems_e - COUNT_BITS'(1);
          if (elems_e == COUNT_BITS'(1)) begin
            ev      = rrp_pkg::EV_REPLY;
            val     = acc_e;
            phase_d = PH_DONE;
          end else begin
            ev      = rrp_pkg::EV_ELEMENT;
            phase_d = PH_ELEM_BEGIN;
          end
        end else begin
          ev      = rrp_pkg::EV_REPLY;
          phase_d = PH_DONE;
        end
      end
      default: begin
        // Reply finished or broken: drop bytes until restart
        ev = rrp_pkg::EV_IGNORED;
      end
    endcase

    if (err) begin
      ev      = rrp_pkg::EV_SYNTAX;
      pay     = '0;
      val     = '0;
      phase_d = PH_ERROR;
    end
  end

  assign res_o.event_res  = ev;
  assign res_o.payload    = pay;
  assign res_o.reply_type = kind_d;
  assign res_o.value      = val;

  // Advance parse state on each processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BEGIN;
      kind_q  <= rrp_pkg::KIND_NIL;
      acc_q   <= '0;
      minus_q <= 1'b0;
      body_q  <= '0;
      elems_q <= '0;
      inarr_q <= 1'b0;
    end else if (step) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      acc_q   <= acc_d;
      minus_q <= minus_d;
      body_q  <= body_d;
      elems_q <= elems_d;
      inarr_q <= inarr_d;
    end
  end

endmodule

@@ rtl/core/rrp_checker.sv @@
// ----------------------------------------------------------------------------
// rrp_checker
// Port-level checks of the reply parser, bound to the top level.
// ----------------------------------------------------------------------------
module rrp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              push,
  input logic              full,
  input rrp_pkg::rrp_in_t  item_i,
  input logic              empty,
  input logic              pop,
  input rrp_pkg::rrp_out_t result_o
);

  // A waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(result_o))
    else $error("result changed while stalled");

  // Payload byte only on payload events
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && result_o.event_res != rrp_pkg::EV_PAYLOAD |-> result_o.payload == 8'd0)
    else $error("payload set on a non-payload event");

  // Value only on reply done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && result_o.event_res != rrp_pkg::EV_REPLY |-> result_o.value == 64'sd0)
    else $error("value set on an event other than reply done");

  // Without a recognised type only errors or ignored bytes appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && result_o.reply_type == rrp_pkg::KIND_NIL |->
      result_o.event_res == rrp_pkg::EV_SYNTAX || result_o.event_res == rrp_pkg::EV_IGNORED)
    else $error("event without a reply type");

  // An accepted byte is not lost: results queue drains into an idle output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full && empty && !$past(!empty) |-> ##2 !empty)
    else $error("accepted byte gave no result");

endmodule

bind resp_reply_parser rrp_checker u_rrp_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .item_i   (item_i),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

@@ verif/resp_reply_parser_checker.sv @@
// ----------------------------------------------------------------------------
// resp_reply_parser_checker
// Watches both queues of the reply parser. Predicts the event of every
// accepted byte, then compares each accepted result, field by field, with
// the oldest prediction. Hands a failure count and a few totals to the top.
// ----------------------------------------------------------------------------
module resp_reply_parser_checker #(
  parameter int unsigned LENGTH_BITS = 32,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              full_i,
  input  rrp_pkg::rrp_in_t  item_i,
  input  logic              empty_i,
  input  logic              pop_i,
  input  rrp_pkg::rrp_out_t result_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       replies_o,
  output int unsigned       elements_o,
  output int unsigned       syntax_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] LENGTH_MAX = (LENGTH_BITS >= 64) ? '1 : (64'd1 << LENGTH_BITS) - 64'd1;
  localparam logic [63:0] COUNT_MAX  = (COUNT_BITS >= 64) ? '1 : (64'd1 << COUNT_BITS) - 64'd1;
  localparam logic [63:0] SAT_MAG    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] INT_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [3:0] {
    PH_BEGIN,
    PH_LINE_FIRST,
    PH_LINE_INT,
    PH_LINE_TEXT,
    PH_LINE_LF,
    PH_CNT_FIRST,
    PH_CNT_MORE,
    PH_CNT_LF,
    PH_ELEM_BEGIN,
    PH_LEN_FIRST,
    PH_LEN_MORE,
    PH_LEN_LF,
    PH_BODY,
    PH_BODY_LF,
    PH_DONE,
    PH_ERROR
  } phase_e;

  // Parser state of the prediction
  phase_e      phase;
  logic [2:0]  kind;
  logic [63:0] accum;
  logic        minus;
  logic [63:0] body_left;
  logic [63:0] elems_left;
  logic        in_array;

  rrp_pkg::rrp_out_t pending_events[$];

  function automatic void clear_parser();
    phase      = PH_BEGIN;
    kind       = rrp_pkg::KIND_NIL;
    accum      = '0;
    minus      = 1'b0;
    body_left  = '0;
    elems_left = '0;
    in_array   = 1'b0;
  endfunction

  // Advance the parser by one byte and return the event it gives
  function automatic rrp_pkg::rrp_out_t parse_byte(rrp_pkg::rrp_in_t it);
    logic [7:0]        b;
    logic [2:0]        ev;
    logic [7:0]        pay;
    logic [63:0]       val;
    logic              bad;
    logic              is_dig;
    logic [3:0]        d;
    rrp_pkg::rrp_out_t r;
    b      = it.rx_byte;
    ev     = rrp_pkg::EV_CONSUMED;
    pay    = '0;
    val    = '0;
    bad    = 1'b0;
    is_dig = (b >= rrp_pkg::CH_ZERO) && (b <= rrp_pkg::CH_NINE);
    d      = 4'(b - rrp_pkg::CH_ZERO);
    if (it.new_reply) clear_parser();

    case (phase)
      PH_BEGIN: begin
        if (b == rrp_pkg::CH_PLUS || b == rrp_pkg::CH_MINUS || b == rrp_pkg::CH_COLON) begin
          kind  = (b == rrp_pkg::CH_PLUS)  ? rrp_pkg::KIND_STATUS :
                  (b == rrp_pkg::CH_MINUS) ? rrp_pkg::KIND_ERROR  : rrp_pkg::KIND_INTEGER;
          phase = PH_LINE_FIRST;
        end else if (b == rrp_pkg::CH_DOLLAR) begin
          kind  = rrp_pkg::KIND_BULK;
          phase = PH_LEN_FIRST;
        end else if (b == rrp_pkg::CH_STAR) begin
          kind  = rrp_pkg::KIND_ARRAY;
          phase = PH_CNT_FIRST;
        end else begin
          bad = 1'b1;
        end
      end
      PH_LINE_FIRST, PH_LINE_INT, PH_LINE_TEXT: begin
        if (b == rrp_pkg::CH_LF || (b == rrp_pkg::CH_CR && phase == PH_LINE_FIRST)) begin
          bad = 1'b1;
        end else if (b == rrp_pkg::CH_CR) begin
          phase = PH_LINE_LF;
        end else begin
          ev  = rrp_pkg::EV_PAYLOAD;
          pay = b;
          // only the leading sign and digits of an integer line count
          if (kind == rrp_pkg::KIND_INTEGER && phase != PH_LINE_TEXT) begin
            if (is_dig) begin
              accum = (accum > (SAT_MAG - d) / 10) ? SAT_MAG : accum * 10 + d;
              phase = PH_LINE_INT;
            end else if (b == rrp_pkg::CH_MINUS && phase == PH_LINE_FIRST) begin
              minus = 1'b1;
              phase = PH_LINE_INT;
            end else begin
              phase = PH_LINE_TEXT;
            end
          end else begin
            phase = PH_LINE_TEXT;
          end
        end
      end
      PH_LINE_LF: begin
        if (b != rrp_pkg::CH_LF) begin
          bad = 1'b1;
        end else begin
          ev = rrp_pkg::EV_REPLY;
          if (kind == rrp_pkg::KIND_INTEGER)
            val = minus ? (~accum + 64'd1) : ((accum > INT_MAX) ? INT_MAX : accum);
          phase = PH_DONE;
        end
      end
      PH_CNT_FIRST, PH_CNT_MORE: begin
        if (is_dig) begin
          if (accum > (COUNT_MAX - d) / 10) begin
            bad = 1'b1;
          end else begin
            accum = accum * 10 + d;
            phase = PH_CNT_MORE;
          end
        end else if (b == rrp_pkg::CH_CR && phase == PH_CNT_MORE) begin
          phase = PH_CNT_LF;
        end else begin
          bad = 1'b1;
        end
      end
      PH_CNT_LF: begin
        if (b != rrp_pkg::CH_LF) begin
          bad = 1'b1;
        end else if (accum == 0) begin
          ev    = rrp_pkg::EV_REPLY;
          phase = PH_DONE;
        end else begin
          in_array   = 1'b1;
          elems_left = accum;
          phase      = PH_ELEM_BEGIN;
        end
      end
      PH_ELEM_BEGIN: begin
        if (b == rrp_pkg::CH_DOLLAR) phase = PH_LEN_FIRST;
        else bad = 1'b1;
      end
      PH_LEN_FIRST, PH_LEN_MORE: begin
        if (is_dig) begin
          if (body_left > (LENGTH_MAX - d) / 10) begin
            bad = 1'b1;
          end else begin
            body_left = body_left * 10 + d;
            phase     = PH_LEN_MORE;
          end
        end else if (b == rrp_pkg::CH_CR && phase == PH_LEN_MORE) begin
          phase = PH_LEN_LF;
        end else begin
          bad = 1'b1;
        end
      end
      PH_LEN_LF: begin
        if (b != rrp_pkg::CH_LF) bad = 1'b1;
        else phase = PH_BODY;
      end
      PH_BODY: begin
        // body bytes of any value pass as payload, CR LF follows
        if (body_left != 0) begin
          body_left = body_left - 1;
          ev        = rrp_pkg::EV_PAYLOAD;
          pay       = b;
        end else if (b == rrp_pkg::CH_CR) begin
          phase = PH_BODY_LF;
        end else begin
          bad = 1'b1;
        end
      end
      PH_BODY_LF: begin
        if (b != rrp_pkg::CH_LF) begin
          bad = 1'b1;
        end else if (in_array) begin
          elems_left = elems_left - 1;
          if (elems_left == 0) begin
            ev    = rrp_pkg::EV_REPLY;
            val   = accum;
            phase = PH_DONE;
          end else begin
            ev    = rrp_pkg::EV_ELEMENT;
            phase = PH_ELEM_BEGIN;
          end
        end else begin
          ev    = rrp_pkg::EV_REPLY;
          phase = PH_DONE;
        end
      end
      default: ev = rrp_pkg::EV_IGNORED;
    endcase

    if (bad) begin
      ev    = rrp_pkg::EV_SYNTAX;
      pay   = '0;
      val   = '0;
      phase = PH_ERROR;
    end

    r.event_res  = ev;
    r.payload    = pay;
    r.reply_type = kind;
    r.value      = val;
    return r;
  endfunction

  task automatic log_failure(input string msg);
    fail_count_o++;
    $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want)
      log_failure($sformatf("%s mismatch, expected %0h, actual %0h", field, want, got));
  endtask

  // Predict on the input queue, compare on the result queue
  always @(posedge clk_i or negedge rst_ni) begin : track
    rrp_pkg::rrp_out_t want;
    if (!rst_ni) begin
      clear_parser();
      pending_events.delete();
      fail_count_o = 0;
      replies_o    = 0;
      elements_o   = 0;
      syntax_o     = 0;
    end else begin
      if (push_i && !full_i) begin
        want           = parse_byte(item_i);
        pending_events = {pending_events, want};
      end
      if (pop_i && !empty_i) begin
        if (pending_events.size() == 0) begin
          log_failure($sformatf("unexpected result, expected none, actual %0h", result_i));
        end else begin
          want = pending_events.pop_front();
          check_field("event_res", want.event_res, result_i.event_res);
          check_field("payload", want.payload, result_i.payload);
          check_field("reply_type", want.reply_type, result_i.reply_type);
          check_field("value", want.value, result_i.value);
          if (want.event_res == rrp_pkg::EV_REPLY) replies_o++;
          if (want.event_res == rrp_pkg::EV_ELEMENT) elements_o++;
          if (want.event_res == rrp_pkg::EV_SYNTAX) syntax_o++;
        end
      end
    end
    pending_o = pending_events.size();
  end

endmodule

@@ verif/tb_resp_reply_parser.sv @@
// ----------------------------------------------------------------------------
// tb_resp_reply_parser
// Drives reply byte streams into the parser: a short directed set of edge
// cases, then random replies, most well formed, some corrupted, cut short or noise,
// over four idling phases. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb_resp_reply_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET  = 1200;
  localparam int unsigned PHASES       = 4;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned NO_POS       = 32'hFFFF_FFFF;

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              push    = 1'b0;
  logic              pop     = 1'b0;
  logic              hold_on = 1'b0;
  logic              full;
  logic              empty;
  rrp_pkg::rrp_in_t  item    = '0;
  rrp_pkg::rrp_out_t result;

  int unsigned fail_count, pending, replies, elements, syntax_errs;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent     = 0;
  int unsigned byte_idx, corrupt_at, cut_at;
  bit          fresh;
  event        hold_go;

  resp_reply_parser dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item),
    .empty    (empty),
    .pop      (pop),
    .result_o (result)
  );

  resp_reply_parser_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .item_i       (item),
    .empty_i      (empty),
    .pop_i        (pop),
    .result_i     (result),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .replies_o    (replies),
    .elements_o   (elements),
    .syntax_o     (syntax_errs)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Stall the result side at random, or hold it off completely
  always @(negedge clk_i) begin
    pop <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
  end

  // Hold off the result side for a long stretch so the input fills up
  initial forever begin
    @(hold_go);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    hold_on = 1'b0;
  end

  initial begin
    #500_000;
    $display("[resp_reply_parser] ERROR");
    $finish;
  end

  // Offer one byte, idling first at random; entered and left at a falling edge
  task automatic send_item(input logic [7:0] b, input logic restart, input bit counted);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push           <= 1'b1;
    item.rx_byte   <= b;
    item.new_reply <= restart;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
    if (counted) items_sent++;
  endtask

  function automatic void start_reply();
    fresh      = 1'b1;
    byte_idx   = 0;
    corrupt_at = NO_POS;
    cut_at     = NO_POS;
  endfunction

  // Send one reply byte, corrupted or dropped where the reply is to be broken
  task automatic put(input logic [7:0] b);
    logic [7:0] v;
    v = b;
    if (byte_idx == corrupt_at) v = 8'($urandom_range(255));
    if (byte_idx < cut_at) begin
      send_item(v, fresh, 1'b1);
      fresh = 1'b0;
    end
    byte_idx++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic put_crlf();
    put(rrp_pkg::CH_CR);
    put(rrp_pkg::CH_LF);
  endtask

  // Line text of random bytes, never CR or LF
  task automatic put_plain(input int unsigned n);
    logic [7:0] c;
    repeat (n) begin
      c = 8'($urandom_range(255));
      if (c == rrp_pkg::CH_CR || c == rrp_pkg::CH_LF) c = c ^ 8'h40;
      put(c);
    end
  endtask

  task automatic put_digits(input int unsigned n, input bit big_lead);
    for (int unsigned i = 0; i < n; i++)
      put(rrp_pkg::CH_ZERO +
          8'((i == 0 && big_lead) ? $urandom_range(9, 5) : $urandom_range(9)));
  endtask

  task automatic put_line();
    put($urandom_range(1) ? rrp_pkg::CH_PLUS : rrp_pkg::CH_MINUS);
    put_plain($urandom_range(1, 8));
    put_crlf();
  endtask

  task automatic put_integer();
    int unsigned sel;
    sel = $urandom_range(99);
    put(rrp_pkg::CH_COLON);
    if ($urandom_range(1)) put(rrp_pkg::CH_MINUS);
    // mostly short numbers, some that saturate, some with no digits
    if (sel < 8) put_digits($urandom_range(18, 22), 1'b0);
    else if (sel >= 15) put_digits($urandom_range(1, 6), 1'b0);
    if ($urandom_range(3) == 0) put_plain($urandom_range(1, 3));
    put_crlf();
  endtask

  task automatic put_bulk();
    int unsigned sel;
    int unsigned len;
    sel = $urandom_range(99);
    put(rrp_pkg::CH_DOLLAR);
    // length too wide for the counter
    if (sel < 3) begin
      put_digits($urandom_range(10, 12), 1'b1);
      put_crlf();
      return;
    end
    len = (sel < 5) ? 64 : $urandom_range(0, 10);
    put_text($sformatf("%0d", len));
    put_crlf();
    repeat (len) put(8'($urandom_range(255)));
    put_crlf();
  endtask

  task automatic put_array();
    int unsigned sel;
    int unsigned n;
    sel = $urandom_range(99);
    put(rrp_pkg::CH_STAR);
    if (sel < 3) begin
      put_digits($urandom_range(10, 12), 1'b1);
      put_crlf();
      return;
    end
    n = $urandom_range(0, 4);
    put_text($sformatf("%0d", n));
    put_crlf();
    repeat (n) put_bulk();
  endtask

  // Mostly well-formed replies; some corrupted, cut short, or plain noise
  task automatic random_reply();
    int unsigned sel;
    sel = $urandom_range(99);
    start_reply();
    if (sel < 10) corrupt_at = $urandom_range(10);
    else if (sel < 15) cut_at = $urandom_range(1, 8);
    if (sel >= 95) begin
      repeat ($urandom_range(1, 4)) put(8'($urandom_range(255)));
      return;
    end
    case ($urandom_range(5))
      0:       put_line();
      1:       put_integer();
      2, 3:    put_bulk();
      default: put_array();
    endcase
    // trailing bytes without a restart are dropped by the parser after a finished or broken reply
    if ($urandom_range(7) == 0)
      repeat ($urandom_range(1, 3)) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
  endtask

  task automatic directed_replies();
    // unknown type byte at the lowest byte value
    start_reply(); put(8'h00);
    // empty lines, ended by CR and by LF
    start_reply(); put(rrp_pkg::CH_PLUS); put(rrp_pkg::CH_CR);
    start_reply(); put(rrp_pkg::CH_MINUS); put(rrp_pkg::CH_LF);
    // LF inside a line, then a stray byte after CR
    start_reply(); put(rrp_pkg::CH_PLUS); put_text("a"); put(rrp_pkg::CH_LF);
    start_reply(); put(rrp_pkg::CH_MINUS); put_text("e"); put(rrp_pkg::CH_CR); put_text("x");
    // negative bulk length, then missing length digits
    start_reply(); put(rrp_pkg::CH_DOLLAR); put(rrp_pkg::CH_MINUS);
    start_reply(); put(rrp_pkg::CH_DOLLAR); put(rrp_pkg::CH_CR);
    // zero count ends at once; the top byte value after it is dropped
    start_reply(); put(rrp_pkg::CH_STAR); put_text("0"); put_crlf(); put(8'hFF);
    // array element that is not a bulk string
    start_reply(); put(rrp_pkg::CH_STAR); put_text("1"); put_crlf(); put(rrp_pkg::CH_COLON);
    // integer with trailing text
    start_reply(); put(rrp_pkg::CH_COLON); put_text("-9z"); put_crlf();
    // two elements, a body holding CR, LF and 0xFF, then an empty body
    start_reply(); put(rrp_pkg::CH_STAR); put_text("2"); put_crlf();
    put(rrp_pkg::CH_DOLLAR); put_text("3"); put_crlf();
    put(rrp_pkg::CH_CR); put(rrp_pkg::CH_LF); put(8'hFF); put_crlf();
    put(rrp_pkg::CH_DOLLAR); put_text("0"); put_crlf(); put_crlf();
    // length and count overflow, integer saturation
    start_reply(); put(rrp_pkg::CH_DOLLAR); put_text("4294967296");
    start_reply(); put(rrp_pkg::CH_STAR); put_text("4294967296");
    start_reply(); put(rrp_pkg::CH_COLON); put_text("99999999999999999999"); put_crlf();
  endtask

  // Settle the queues and the result side before the next phase
  task automatic drain();
    push <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    directed_replies();
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      if (p == 0) -> hold_go;
      while (items_sent < ITEM_TARGET * (p + 1) / PHASES) random_reply();
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d reply bytes over four idling phases with one long result hold-off.",
             items_sent);
    $display("Saw %0d finished replies, %0d array elements and %0d syntax errors.",
             replies, elements, syntax_errs);
    if (fail_count == 0) begin
      $display("[resp_reply_parser] OK");
    end else begin
      $display("[resp_reply_parser] ERROR");
    end
    $finish;
  end

endmodule
